@@ src/btnrep_pkg.sv @@
// Shared constants for the button auto-repeat latch.
package btnrep_pkg;

    // Number of buttons that are actually tracked (1 to 32).
    localparam int NUM_BUTTONS = 32;

    // Fixed field widths.
    localparam int BTN_W   = 32;
    localparam int TIMER_W = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Width of the button index used by the sequencer.
    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Bits of a frame that belong to tracked buttons.
    localparam logic [BTN_W-1:0] BTN_MASK =
        BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_VALUE     = 1'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd30;
    localparam logic [CFG_W-1:0] RELOAD_RST    = 8'd24;

endpackage

@@ src/button_autorepeat_latch_core.sv @@
// Top level of the button auto-repeat latch: edge detection, per-button repeat timers, hold.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-------------------------------
//  input    | in        | in_valid / in_stall | buttons, tick_step, hold
//  output   | out       | out_valid/out_stall | held, pressed, repeat_res
//  config   | in        | cfg_we              | cfg_index, cfg_data
//
// An item is handled in steps: the block accepts it, walks the buttons in turn while the
// single shared 8-bit add and compare unit updates each button's timer, and loads the
// result register, merging the pending bits in (hold clear) or adding to them (hold set).
// The block takes no new item until the result register has been loaded, but it takes
// the next item while that result still waits on out_stall.
// Reset clears the timers, previous levels and pending bits, and loads 30 and 24.
module button_autorepeat_latch_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [btnrep_pkg::BTN_W-1:0]       buttons,
    input  logic [btnrep_pkg::TIMER_W-1:0]     tick_step,
    input  logic                               hold,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [btnrep_pkg::BTN_W-1:0]       held,
    output logic [btnrep_pkg::BTN_W-1:0]       pressed,
    output logic [btnrep_pkg::BTN_W-1:0]       repeat_res,

    input  logic                               cfg_we,
    input  logic [btnrep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btnrep_pkg::CFG_W-1:0]       cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [btnrep_pkg::IDX_W-1:0] LAST_IDX =
        btnrep_pkg::IDX_W'(btnrep_pkg::NUM_BUTTONS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [btnrep_pkg::IDX_W-1:0]        idx_reg;

    // Configuration registers.
    logic [btnrep_pkg::CFG_W-1:0]        threshold_reg;
    logic [btnrep_pkg::CFG_W-1:0]        reload_reg;

    // Per-frame working registers captured on accept.
    logic [btnrep_pkg::BTN_W-1:0]        cur_reg;
    logic [btnrep_pkg::BTN_W-1:0]        newly_reg;
    logic [btnrep_pkg::BTN_W-1:0]        rep_reg;
    logic [btnrep_pkg::TIMER_W-1:0]      step_reg;
    logic                                hold_reg;

    // Persistent state.
    logic [btnrep_pkg::BTN_W-1:0]        prev_reg;
    logic [btnrep_pkg::BTN_W-1:0]        pend_rep_reg;
    logic [btnrep_pkg::BTN_W-1:0]        pend_prs_reg;
    logic [btnrep_pkg::TIMER_W-1:0]      timers_reg [btnrep_pkg::NUM_BUTTONS];

    // Result register.
    logic                                out_valid_reg;
    logic [btnrep_pkg::BTN_W-1:0]        held_reg;
    logic [btnrep_pkg::BTN_W-1:0]        pressed_reg;
    logic [btnrep_pkg::BTN_W-1:0]        repeat_reg;

    logic                                in_acc;
    logic                                out_acc;
    logic                                fin_go;
    logic [btnrep_pkg::BTN_W-1:0]        cur_in;

    // Shared timer unit signals.
    logic [btnrep_pkg::TIMER_W-1:0]      t_sum;
    logic                                t_hit;
    logic                                t_fire;
    logic [btnrep_pkg::TIMER_W-1:0]      timer_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign fin_go    = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign cur_in    = buttons & btnrep_pkg::BTN_MASK;

    assign out_valid  = out_valid_reg;
    assign held       = held_reg;
    assign pressed    = pressed_reg;
    assign repeat_res = repeat_reg;

    // The one add and compare unit, applied to the button that idx_reg selects. A
    // button fires on its press or when its wrapped timer reaches the threshold;
    // a released button has its timer cleared.
    always_comb
    begin
        t_sum  = timers_reg[idx_reg] + step_reg;
        t_hit  = (t_sum >= threshold_reg);
        t_fire = cur_reg[idx_reg] && (newly_reg[idx_reg] || t_hit);
        if (!cur_reg[idx_reg])
        begin
            timer_next = '0;
        end
        else if (t_hit)
        begin
            timer_next = reload_reg;
        end
        else
        begin
            timer_next = t_sum;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            threshold_reg <= btnrep_pkg::THRESHOLD_RST;
            reload_reg    <= btnrep_pkg::RELOAD_RST;
            prev_reg      <= '0;
            pend_rep_reg  <= '0;
            pend_prs_reg  <= '0;
            for (int k = 0; k < btnrep_pkg::NUM_BUTTONS; k++)
            begin
                timers_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    btnrep_pkg::CFG_REPEAT_THRESHOLD: threshold_reg <= cfg_data;
                    btnrep_pkg::CFG_RELOAD_VALUE:     reload_reg    <= cfg_data;
                    default:                          ;
                endcase
            end

            if (in_acc)
            begin
                idx_reg  <= '0;
                prev_reg <= cur_in;
            end
            else if (state_reg == ST_RUN)
            begin
                timers_reg[idx_reg] <= timer_next;
                if (idx_reg != LAST_IDX)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
                if (hold_reg)
                begin
                    pend_rep_reg <= pend_rep_reg | rep_reg;
                    pend_prs_reg <= pend_prs_reg | newly_reg;
                end
                else
                begin
                    pend_rep_reg <= '0;
                    pend_prs_reg <= '0;
                end
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_reg   <= cur_in;
            newly_reg <= (prev_reg ^ cur_in) & cur_in;
            step_reg  <= tick_step;
            hold_reg  <= hold;
            rep_reg   <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            rep_reg[idx_reg] <= t_fire;
        end

        if (fin_go)
        begin
            held_reg <= cur_reg;
            if (hold_reg)
            begin
                pressed_reg <= newly_reg;
                repeat_reg  <= rep_reg;
            end
            else
            begin
                pressed_reg <= newly_reg | pend_prs_reg;
                repeat_reg  <= rep_reg | pend_rep_reg;
            end
        end
    end

`ifndef SYNTHESIS
    // An accepted item starts the timer walk at the first button.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_RUN) && (idx_reg == '0))
        else $error("timer walk did not start at the first button");

    // The walk ends at the last button and moves on to the merge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (idx_reg == LAST_IDX) |=> (state_reg == ST_FINISH))
        else $error("timer walk did not end after the last button");

    // A result only appears from the merge step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the merge step");

    // Releasing hold empties the pending bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_go && !hold_reg |=> (pend_rep_reg == '0) && (pend_prs_reg == '0))
        else $error("pending bits survived a release");
`endif

endmodule

@@ tb/button_autorepeat_latch_core_test.sv @@
// Self-checking testbench for the button auto-repeat latch core, with a built-in frame predictor.
`timescale 1ns / 100ps

// The testbench drives frames of button levels into the core and checks every
// result frame against its own model of the core. The model covers edge
// detection, the per-button repeat timers with their 8-bit wrap, and the
// pending bits that build up while hold is set.
//
// Inputs change on the falling clock edge. Outputs are sampled on the rising
// edge, so every check sees values that have settled before that edge. In
// some tests the sender works in bursts with random gaps. The receiver
// stalls in one of three patterns, chosen by each test, so that gaps and
// stalls land at varied points of the core's per-button walk.
module button_autorepeat_latch_core_test;

    // The time of one item: the accept, the walk over the buttons and the merge.
    localparam int ITEM_CYCLES = btnrep_pkg::NUM_BUTTONS + 2;
    // This limit lies well above the slowest correct run and leaves a wide margin.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_PHASES = 5;
    localparam int FRAMES_PER_PHASE = 400;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTS} stall_pattern_t;

    typedef logic [btnrep_pkg::TIMER_W-1:0] timer_t;
    typedef logic [btnrep_pkg::CFG_W-1:0]   cfg_val_t;

    // One result frame as the core reports it.
    typedef struct packed {
        logic [btnrep_pkg::BTN_W-1:0] held;
        logic [btnrep_pkg::BTN_W-1:0] pressed;
        logic [btnrep_pkg::BTN_W-1:0] repeats;
    } frame_result_t;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               in_valid   = 1'b0;
    logic                               in_stall;
    logic [btnrep_pkg::BTN_W-1:0]       buttons    = '0;
    logic [btnrep_pkg::TIMER_W-1:0]     tick_step  = '0;
    logic                               hold       = 1'b0;
    logic                               out_valid;
    logic                               out_stall  = 1'b0;
    logic [btnrep_pkg::BTN_W-1:0]       held;
    logic [btnrep_pkg::BTN_W-1:0]       pressed;
    logic [btnrep_pkg::BTN_W-1:0]       repeat_res;
    logic                               cfg_we     = 1'b0;
    logic [btnrep_pkg::CFG_IDX_W-1:0]   cfg_index  = btnrep_pkg::CFG_REPEAT_THRESHOLD;
    logic [btnrep_pkg::CFG_W-1:0]       cfg_data   = '0;

    // The predictor's copy of the core's registers and state.
    logic [btnrep_pkg::CFG_W-1:0]       model_threshold   = btnrep_pkg::THRESHOLD_RST;
    logic [btnrep_pkg::CFG_W-1:0]       model_reload      = btnrep_pkg::RELOAD_RST;
    logic [btnrep_pkg::BTN_W-1:0]       model_prev        = '0;
    logic [btnrep_pkg::BTN_W-1:0]       model_pend_press  = '0;
    logic [btnrep_pkg::BTN_W-1:0]       model_pend_repeat = '0;
    logic [btnrep_pkg::TIMER_W-1:0]     model_timer [btnrep_pkg::BTN_W] = '{default: '0};

    // Frames that the core has accepted and whose results are still due.
    frame_result_t          expected_frames [$];
    frame_result_t          head_frame;

    int                     frames_sent    = 0;
    int                     frames_checked = 0;
    int                     error_count    = 0;
    int                     cfg_writes     = 0;
    int                     cycle_count    = 0;

    // Sender and receiver pacing.
    bit                     sender_idles   = 1'b0;
    int                     burst_left     = 0;
    stall_pattern_t         stall_mode     = STALL_NONE;
    int                     stall_run      = 0;

    // State of the random frame generator.
    logic [btnrep_pkg::BTN_W-1:0]   gen_levels     = '0;
    logic                           gen_hold       = 1'b0;
    int                             hold_run       = 0;

    button_autorepeat_latch_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .buttons    (buttons),
        .tick_step  (tick_step),
        .hold       (hold),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .held       (held),
        .pressed    (pressed),
        .repeat_res (repeat_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Works out the result of one frame and advances the model state. A held
    // button repeats when it is newly pressed, or when its timer, after the
    // step is added with an 8-bit wrap, reaches the threshold; in that case
    // the timer reloads. Released buttons clear their timers. With hold set
    // the events also go into the pending bits; with hold clear the pending
    // bits are merged into the result and then cleared.
    function automatic frame_result_t predict_frame(
        input logic [btnrep_pkg::BTN_W-1:0] levels,
        input logic [btnrep_pkg::TIMER_W-1:0] step_amt,
        input logic hold_flag);
        logic [btnrep_pkg::BTN_W-1:0]   cur;
        logic [btnrep_pkg::BTN_W-1:0]   rise;
        logic [btnrep_pkg::BTN_W-1:0]   rpt;
        logic [btnrep_pkg::TIMER_W-1:0] t;
        frame_result_t                  r;
        cur  = levels & btnrep_pkg::BTN_MASK;
        rise = cur & ~model_prev;
        rpt  = rise;
        model_prev = cur;
        for (int k = 0; k < btnrep_pkg::BTN_W; k++)
        begin
            if (cur[k])
            begin
                t = model_timer[k] + step_amt;
                if (t >= model_threshold)
                begin
                    t      = model_reload;
                    rpt[k] = 1'b1;
                end
                model_timer[k] = t;
            end
            else
            begin
                model_timer[k] = '0;
            end
        end
        if (hold_flag)
        begin
            model_pend_repeat |= rpt;
            model_pend_press  |= rise;
        end
        else
        begin
            rise |= model_pend_press;
            rpt  |= model_pend_repeat;
            model_pend_repeat = '0;
            model_pend_press  = '0;
        end
        r.held    = cur;
        r.pressed = rise;
        r.repeats = rpt;
        return r;
    endfunction

    // Presents one frame and holds it until the core takes it. When the
    // sender idles, each burst ends with a gap of random length; otherwise
    // valid stays high so that the next frame follows at once.
    task automatic send_frame(input logic [btnrep_pkg::BTN_W-1:0] levels,
                              input logic [btnrep_pkg::TIMER_W-1:0] step_amt,
                              input logic hold_flag);
        int gap;
        @(negedge clk);
        in_valid  = 1'b1;
        buttons   = levels;
        tick_step = step_amt;
        hold      = hold_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_frames.push_back(predict_frame(levels, step_amt, hold_flag));
        frames_sent++;
        if (sender_idles)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 45);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(0, 6);
            end
        end
    endtask

    // Drops valid and waits until every result is in, then lets the core's
    // item time pass so that it is surely idle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (ITEM_CYCLES) @(negedge clk);
    endtask

    // Writes one register; only called while the core is idle.
    task automatic write_reg(input logic [btnrep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btnrep_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            btnrep_pkg::CFG_REPEAT_THRESHOLD: model_threshold = val;
            btnrep_pkg::CFG_RELOAD_VALUE:     model_reload    = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_registers(input logic [btnrep_pkg::CFG_W-1:0] thr,
                                 input logic [btnrep_pkg::CFG_W-1:0] rld);
        write_reg(btnrep_pkg::CFG_REPEAT_THRESHOLD, thr);
        write_reg(btnrep_pkg::CFG_RELOAD_VALUE, rld);
    endtask

    // The next frame of the random stream. Most frames keep the previous
    // levels with a few buttons flipped, so buttons stay held long enough for
    // their timers to climb; the rest are noise, all released or all held.
    // Hold comes in runs so that pending bits build up over several frames.
    task automatic next_random_frame(output logic [btnrep_pkg::BTN_W-1:0] levels,
                                     output logic [btnrep_pkg::TIMER_W-1:0] step_amt,
                                     output logic hold_flag);
        case ($urandom_range(0, 9))
            0: gen_levels = $urandom;
            1: gen_levels = '0;
            2: gen_levels = '1;
            default: gen_levels ^= $urandom & $urandom & $urandom;
        endcase
        case ($urandom_range(0, 7))
            0: step_amt = timer_t'($urandom_range(0, 255));
            1: step_amt = '0;
            default: step_amt = timer_t'($urandom_range(1, 16));
        endcase
        if (hold_run == 0)
        begin
            gen_hold = ($urandom_range(0, 9) < 3);
            hold_run = $urandom_range(1, 10);
        end
        hold_run--;
        levels    = gen_levels;
        hold_flag = gen_hold;
    endtask

    // Checks a single field of a result frame.
    task automatic check_field(input string fname,
                               input logic [btnrep_pkg::BTN_W-1:0] exp_v,
                               input logic [btnrep_pkg::BTN_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $display("%0t: result %0d, %s: expected %08h, actual %08h",
                     $time, frames_checked, fname, exp_v, act_v);
        end
    endtask

    // Every result taken from the core is matched against the oldest frame
    // still due.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_frames.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no frame due: held %08h pressed %08h repeat %08h",
                         $time, held, pressed, repeat_res);
            end
            else
            begin
                head_frame = expected_frames.pop_front();
                check_field("held", head_frame.held, held);
                check_field("pressed", head_frame.pressed, pressed);
                check_field("repeat_res", head_frame.repeats, repeat_res);
                frames_checked++;
            end
        end
    end

    // The receiver's stall pattern: off, random per cycle, or long runs of
    // stall and release.
    always @(negedge clk)
    begin
        case (stall_mode)
            STALL_NONE:   out_stall = 1'b0;
            STALL_RANDOM: out_stall = ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0)
                begin
                    out_stall = ~out_stall;
                    stall_run = out_stall ? $urandom_range(1, 60) : $urandom_range(1, 40);
                end
                else
                begin
                    stall_run--;
                end
            end
        endcase
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, expected_frames.size());
            $display("button_autorepeat_latch_core_test failed");
            $finish;
        end
    end

    // Frames at the reset register values: no buttons, all buttons pressed at
    // once, a timer just under and just at the threshold, a wrap of the timer
    // sum, a release, hold building up the pending bits on the top and bottom
    // buttons, and the release of hold merging them in.
    task automatic test_directed_frames();
        sender_idles = 1'b0;
        stall_mode   = STALL_RANDOM;
        send_frame(32'h0000_0000, 8'd0, 1'b0);
        send_frame(32'hFFFF_FFFF, 8'd0, 1'b0);
        send_frame(32'hFFFF_FFFF, 8'd29, 1'b0);
        send_frame(32'hFFFF_FFFF, 8'd1, 1'b0);
        send_frame(32'hFFFF_FFFF, 8'd255, 1'b0);
        send_frame(32'h0000_0000, 8'd255, 1'b0);
        send_frame(32'h8000_0000, 8'd10, 1'b1);
        send_frame(32'h8000_0000, 8'd10, 1'b1);
        send_frame(32'h0000_0001, 8'd200, 1'b1);
        send_frame(32'h0000_0001, 8'd0, 1'b0);
        send_frame(32'hAAAA_AAAA, 8'd128, 1'b0);
        send_frame(32'h5555_5555, 8'd127, 1'b0);
        wait_idle();
    endtask

    // Register extremes: a zero threshold makes every held button repeat in
    // every frame; the largest threshold and both reload extremes follow.
    task automatic test_register_extremes();
        logic [btnrep_pkg::CFG_W-1:0] thr_list [3];
        logic [btnrep_pkg::CFG_W-1:0] rld_list [3];
        thr_list = '{8'd0, 8'd255, 8'd255};
        rld_list = '{8'd255, 8'd0, 8'd255};
        sender_idles = 1'b1;
        stall_mode   = STALL_BURSTS;
        for (int p = 0; p < 3; p++)
        begin
            set_registers(thr_list[p], rld_list[p]);
            send_frame(32'hFFFF_FFFF, 8'd1, 1'b0);
            send_frame(32'hFFFF_FFFF, 8'd255, 1'b1);
            send_frame(32'h0F0F_0F0F, 8'd254, 1'b1);
            send_frame(32'h0F0F_0F0F, 8'd1, 1'b0);
            wait_idle();
        end
    endtask

    // The sender holds off after each frame until its result is in, so the
    // core is seen starting from a fully drained state.
    task automatic test_drained_frames();
        logic [btnrep_pkg::BTN_W-1:0]   levels;
        logic [btnrep_pkg::TIMER_W-1:0] step_amt;
        logic                           hold_flag;
        sender_idles = 1'b0;
        stall_mode   = STALL_RANDOM;
        set_registers(btnrep_pkg::THRESHOLD_RST, btnrep_pkg::RELOAD_RST);
        for (int n = 0; n < 15; n++)
        begin
            next_random_frame(levels, step_amt, hold_flag);
            send_frame(levels, step_amt, hold_flag);
            @(negedge clk);
            in_valid = 1'b0;
            while (expected_frames.size() != 0)
                @(negedge clk);
        end
        wait_idle();
    endtask

    // Random frame streams under several register settings and pacing
    // patterns; the first phase runs with no idling on either side.
    task automatic test_random_frames();
        logic [btnrep_pkg::BTN_W-1:0]   levels;
        logic [btnrep_pkg::TIMER_W-1:0] step_amt;
        logic                           hold_flag;
        logic [btnrep_pkg::CFG_W-1:0]   thr;
        logic [btnrep_pkg::CFG_W-1:0]   rld;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr = btnrep_pkg::THRESHOLD_RST;
                    rld = btnrep_pkg::RELOAD_RST;
                end
                1:
                begin
                    thr = cfg_val_t'($urandom_range(0, 255));
                    rld = cfg_val_t'($urandom_range(0, 255));
                end
                2:
                begin
                    thr = '0;
                    rld = cfg_val_t'($urandom_range(0, 255));
                end
                3:
                begin
                    thr = '1;
                    rld = '0;
                end
                default:
                begin
                    thr = cfg_val_t'($urandom_range(16, 64));
                    rld = '1;
                end
            endcase
            set_registers(thr, rld);
            sender_idles = (phase != 0);
            case (phase % 3)
                0:       stall_mode = (phase == 0) ? STALL_NONE : STALL_BURSTS;
                1:       stall_mode = STALL_RANDOM;
                default: stall_mode = STALL_BURSTS;
            endcase
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                next_random_frame(levels, step_amt, hold_flag);
                send_frame(levels, step_amt, hold_flag);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_register_extremes();
        test_drained_frames();
        test_random_frames();

        // wait_idle at the end of each test has already drained the core and
        // waited out the core's item time, so any stray result would have shown up.
        stall_mode = STALL_NONE;
        repeat (ITEM_CYCLES) @(negedge clk);
        $display("Sent %0d frames and checked %0d results with %0d register writes,",
                 frames_sent, frames_checked, cfg_writes);
        $display("covering edges, timer wrap, hold with pending merge and register extremes.");
        if (error_count == 0 && expected_frames.size() == 0)
        begin
            $display("button_autorepeat_latch_core_test passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, expected_frames.size());
            $display("button_autorepeat_latch_core_test failed");
        end
        $finish;
    end

endmodule
